// ===== src/tlqe_pkg.sv =====
// ----------------------------------------------------------------------------
// Thick line quad expander package
// Shared types and constants for the quad expander and its arithmetic units.
// ----------------------------------------------------------------------------
package tlqe_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_INDEX_W-1:0] CFG_SIM_WIDTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIM_HEIGHT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_HEIGHT = 3'd3;

    localparam int SQRT_RAD_W  = 64;
    localparam int SQRT_ROOT_W = 32;
    localparam int SQRT_STEPS  = 32;

    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_QUO_W  = 36;
    localparam int DIV_HEAD_W = DIV_NUM_W - DIV_QUO_W;

    localparam logic [2:0] SLOT_LAST = 3'd5;

    typedef struct packed {
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic signed [23:0] end_x;
        logic signed [23:0] end_y;
        logic [15:0]        thickness;
        logic [15:0]        color_red;
        logic [15:0]        color_green;
        logic [15:0]        color_blue;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic [15:0]        out_red;
        logic [15:0]        out_green;
        logic [15:0]        out_blue;
        logic [2:0]         vertex_slot;
        logic               last_vertex;
    } out_item_t;

endpackage

// ===== src/tlqe_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Produces floor(sqrt(radicand)), one result bit per register stage.
// ----------------------------------------------------------------------------
module tlqe_sqrt (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [tlqe_pkg::SQRT_RAD_W-1:0]    radicand,
    output logic [tlqe_pkg::SQRT_ROOT_W-1:0]   root
);

    logic [tlqe_pkg::SQRT_RAD_W-1:0] v_reg  [tlqe_pkg::SQRT_STEPS];
    logic [tlqe_pkg::SQRT_RAD_W-1:0] r_reg  [tlqe_pkg::SQRT_STEPS];
    logic [tlqe_pkg::SQRT_RAD_W-1:0] v_next [tlqe_pkg::SQRT_STEPS];
    logic [tlqe_pkg::SQRT_RAD_W-1:0] r_next [tlqe_pkg::SQRT_STEPS];

    always_comb begin
        logic [tlqe_pkg::SQRT_RAD_W-1:0] v_in;
        logic [tlqe_pkg::SQRT_RAD_W-1:0] r_in;
        logic [tlqe_pkg::SQRT_RAD_W-1:0] bit_w;
        logic [tlqe_pkg::SQRT_RAD_W-1:0] trial;
        for (int i = 0; i < tlqe_pkg::SQRT_STEPS; i++) begin
            if (i == 0) begin
                v_in = radicand;
                r_in = '0;
            end else begin
                v_in = v_reg[i-1];
                r_in = r_reg[i-1];
            end
            bit_w = tlqe_pkg::SQRT_RAD_W'(1) << (tlqe_pkg::SQRT_RAD_W - 2 - 2 * i);
            trial = r_in + bit_w;
            if (v_in >= trial) begin
                v_next[i] = v_in - trial;
                r_next[i] = (r_in >> 1) + bit_w;
            end else begin
                v_next[i] = v_in;
                r_next[i] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < tlqe_pkg::SQRT_STEPS; i++) begin
                v_reg[i] <= v_next[i];
                r_reg[i] <= r_next[i];
            end
        end
    end

    assign root = r_reg[tlqe_pkg::SQRT_STEPS-1][tlqe_pkg::SQRT_ROOT_W-1:0];

endmodule

// ===== src/tlqe_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned floor division, one quotient bit per register stage. The caller
// guarantees that the quotient fits the quotient width.
// ----------------------------------------------------------------------------
module tlqe_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [tlqe_pkg::DIV_NUM_W-1:0]    num,
    input  logic [tlqe_pkg::DIV_DEN_W-1:0]    den,
    output logic [tlqe_pkg::DIV_QUO_W-1:0]    quo
);

    logic [tlqe_pkg::DIV_DEN_W-1:0] rem_reg  [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_QUO_W-1:0] low_reg  [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_QUO_W-1:0] quo_reg  [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_DEN_W-1:0] den_reg  [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_DEN_W-1:0] rem_next [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_QUO_W-1:0] low_next [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_QUO_W-1:0] quo_next [tlqe_pkg::DIV_QUO_W];
    logic [tlqe_pkg::DIV_DEN_W-1:0] den_next [tlqe_pkg::DIV_QUO_W];

    always_comb begin
        logic [tlqe_pkg::DIV_DEN_W-1:0] rem_in;
        logic [tlqe_pkg::DIV_QUO_W-1:0] low_in;
        logic [tlqe_pkg::DIV_QUO_W-1:0] quo_in;
        logic [tlqe_pkg::DIV_DEN_W-1:0] den_in;
        logic [tlqe_pkg::DIV_DEN_W:0]   trial;
        logic [tlqe_pkg::DIV_DEN_W:0]   diff;
        logic                           ge;
        for (int i = 0; i < tlqe_pkg::DIV_QUO_W; i++) begin
            if (i == 0) begin
                rem_in = tlqe_pkg::DIV_DEN_W'(num[tlqe_pkg::DIV_NUM_W-1:tlqe_pkg::DIV_QUO_W]);
                low_in = num[tlqe_pkg::DIV_QUO_W-1:0];
                quo_in = '0;
                den_in = den;
            end else begin
                rem_in = rem_reg[i-1];
                low_in = low_reg[i-1];
                quo_in = quo_reg[i-1];
                den_in = den_reg[i-1];
            end
            trial       = {rem_in, low_in[tlqe_pkg::DIV_QUO_W-1]};
            diff        = trial - {1'b0, den_in};
            ge          = trial >= {1'b0, den_in};
            rem_next[i] = ge ? diff[tlqe_pkg::DIV_DEN_W-1:0] : trial[tlqe_pkg::DIV_DEN_W-1:0];
            low_next[i] = {low_in[tlqe_pkg::DIV_QUO_W-2:0], 1'b0};
            quo_next[i] = {quo_in[tlqe_pkg::DIV_QUO_W-2:0], ge};
            den_next[i] = den_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < tlqe_pkg::DIV_QUO_W; i++) begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                quo_reg[i] <= quo_next[i];
                den_reg[i] <= den_next[i];
            end
        end
    end

    assign quo = quo_reg[tlqe_pkg::DIV_QUO_W-1];

endmodule

// ===== src/thick_line_quad_expander.sv =====
// ----------------------------------------------------------------------------
// Thick line quad expander
// Expands a line segment with a thickness into two triangles in normalized
// device coordinates.
// ----------------------------------------------------------------------------
// A segment transaction is accepted on the s_ channel and its six vertices
// later appear on the m_ channel in the order v0,v1,v2,v2,v3,v0, one vertex
// per cycle while m_ready is high. A zero-length segment produces no vertices.
// The datapath is a single stalling pipeline: a 32-stage square root, 36-stage
// dividers for the unit normal and thickness scale, a multiply stage and
// 36-stage dividers for the device-coordinate mapping. Segments enter back to
// back until stage K holds a segment the busy vertex output register cannot
// take; the sustained rate is then one segment per six vertex transfers, set by
// the output channel. Configuration registers are written through cfg_wr_en and
// take effect at once, so write them only while no segment is in flight.
module thick_line_quad_expander (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tlqe_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tlqe_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [tlqe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tlqe_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } color_t;

    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
        color_t             color;
    } geom_t;

    typedef struct packed {
        geom_t       geom;
        logic [24:0] adx;
        logic [24:0] ady;
        logic        negx;
        logic        posy;
        logic [28:0] tpx;
        logic [28:0] tpy;
    } sq_side_t;

    typedef struct packed {
        geom_t geom;
        logic  negx;
        logic  posy;
    } dv_side_t;

    typedef struct packed {
        color_t     color;
        logic [7:0] neg;
    } nd_side_t;

    localparam int NCOORD = 8;

    // Configuration
    logic [12:0] sim_width_reg;
    logic [12:0] sim_height_reg;
    logic [13:0] window_width_reg;
    logic [13:0] window_height_reg;
    logic [12:0] sw_nz;
    logic [12:0] sh_nz;
    logic [13:0] ww_nz;
    logic [13:0] wh_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sim_width_reg     <= 13'd1024;
            sim_height_reg    <= 13'd1024;
            window_width_reg  <= 14'd1024;
            window_height_reg <= 14'd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tlqe_pkg::CFG_SIM_WIDTH:     sim_width_reg     <= cfg_wdata[12:0];
                tlqe_pkg::CFG_SIM_HEIGHT:    sim_height_reg    <= cfg_wdata[12:0];
                tlqe_pkg::CFG_WINDOW_WIDTH:  window_width_reg  <= cfg_wdata;
                tlqe_pkg::CFG_WINDOW_HEIGHT: window_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sw_nz = (sim_width_reg == '0) ? 13'd1 : sim_width_reg;
    assign sh_nz = (sim_height_reg == '0) ? 13'd1 : sim_height_reg;
    assign ww_nz = (window_width_reg == '0) ? 14'd1 : window_width_reg;
    assign wh_nz = (window_height_reg == '0) ? 14'd1 : window_height_reg;

    // Pipeline control
    logic ce;
    logic buf_free;
    logic buf_valid_reg;
    logic [2:0] buf_slot_reg;
    logic k_valid_reg;

    assign buf_free = !buf_valid_reg || (m_ready && buf_slot_reg == tlqe_pkg::SLOT_LAST);
    assign ce       = !k_valid_reg || buf_free;
    assign s_ready  = ce;

    // Stage B: differences
    logic               b_valid_reg;
    geom_t              b_geom_reg;
    logic [15:0]        b_thick_reg;
    logic signed [24:0] b_dx_reg;
    logic signed [24:0] b_dy_reg;
    logic signed [24:0] dx_c;
    logic signed [24:0] dy_c;

    assign dx_c = {s_data.end_x[23], s_data.end_x} - {s_data.start_x[23], s_data.start_x};
    assign dy_c = {s_data.end_y[23], s_data.end_y} - {s_data.start_y[23], s_data.start_y};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (ce) begin
            b_valid_reg <= s_valid && (dx_c != '0 || dy_c != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_geom_reg  <= '{sx: s_data.start_x, sy: s_data.start_y,
                             ex: s_data.end_x, ey: s_data.end_y,
                             color: '{red: s_data.color_red, green: s_data.color_green,
                                      blue: s_data.color_blue}};
            b_thick_reg <= s_data.thickness;
            b_dx_reg    <= dx_c;
            b_dy_reg    <= dy_c;
        end
    end

    // Stage C: squares and thickness products
    logic        c_valid_reg;
    sq_side_t    c_side_reg;
    logic [48:0] c_sqx_reg;
    logic [48:0] c_sqy_reg;
    logic [24:0] adx_c;
    logic [24:0] ady_c;
    logic [49:0] sqsum_c;
    logic [tlqe_pkg::SQRT_RAD_W-1:0] radicand_c;

    assign adx_c = b_dx_reg[24] ? 25'(-b_dx_reg) : 25'(b_dx_reg);
    assign ady_c = b_dy_reg[24] ? 25'(-b_dy_reg) : 25'(b_dy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (ce) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_sqx_reg       <= 49'(adx_c * adx_c);
            c_sqy_reg       <= 49'(ady_c * ady_c);
            c_side_reg.geom <= b_geom_reg;
            c_side_reg.adx  <= adx_c;
            c_side_reg.ady  <= ady_c;
            c_side_reg.negx <= b_dx_reg[24];
            c_side_reg.posy <= !b_dy_reg[24] && (b_dy_reg != '0);
            c_side_reg.tpx  <= 29'(b_thick_reg * sw_nz);
            c_side_reg.tpy  <= 29'(b_thick_reg * sh_nz);
        end
    end

    assign sqsum_c    = 50'(c_sqx_reg) + 50'(c_sqy_reg);
    assign radicand_c = {sqsum_c, 14'd0};

    // Square root section
    logic [tlqe_pkg::SQRT_STEPS-1:0]  sq_valid_reg;
    sq_side_t                         sq_side_reg [tlqe_pkg::SQRT_STEPS];
    logic [tlqe_pkg::SQRT_ROOT_W-1:0] len_c;
    sq_side_t                         sq_tail;

    tlqe_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (ce),
        .radicand (radicand_c),
        .root     (len_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= '0;
        end else if (ce) begin
            sq_valid_reg <= {sq_valid_reg[tlqe_pkg::SQRT_STEPS-2:0], c_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq_side_reg[0] <= c_side_reg;
            for (int i = 1; i < tlqe_pkg::SQRT_STEPS; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    assign sq_tail = sq_side_reg[tlqe_pkg::SQRT_STEPS-1];

    // Normal and thickness dividers
    logic [tlqe_pkg::DIV_NUM_W-1:0] nux_c;
    logic [tlqe_pkg::DIV_NUM_W-1:0] nuy_c;
    logic [tlqe_pkg::DIV_NUM_W-1:0] ntx_c;
    logic [tlqe_pkg::DIV_NUM_W-1:0] nty_c;
    logic [tlqe_pkg::DIV_QUO_W-1:0] qux;
    logic [tlqe_pkg::DIV_QUO_W-1:0] quy;
    logic [tlqe_pkg::DIV_QUO_W-1:0] qtx;
    logic [tlqe_pkg::DIV_QUO_W-1:0] qty;

    assign nux_c = tlqe_pkg::DIV_NUM_W'({sq_tail.ady, 22'd0})
                 + tlqe_pkg::DIV_NUM_W'(len_c >> 1);
    assign nuy_c = tlqe_pkg::DIV_NUM_W'({sq_tail.adx, 22'd0})
                 + tlqe_pkg::DIV_NUM_W'(len_c >> 1);
    assign ntx_c = tlqe_pkg::DIV_NUM_W'({sq_tail.tpx, 7'd0})
                 + tlqe_pkg::DIV_NUM_W'(ww_nz >> 1);
    assign nty_c = tlqe_pkg::DIV_NUM_W'({sq_tail.tpy, 7'd0})
                 + tlqe_pkg::DIV_NUM_W'(wh_nz >> 1);

    tlqe_div u_div_ux (.aclk(aclk), .en(ce), .num(nux_c), .den(len_c), .quo(qux));
    tlqe_div u_div_uy (.aclk(aclk), .en(ce), .num(nuy_c), .den(len_c), .quo(quy));
    tlqe_div u_div_tx (.aclk(aclk), .en(ce), .num(ntx_c),
                       .den(tlqe_pkg::DIV_DEN_W'(ww_nz)), .quo(qtx));
    tlqe_div u_div_ty (.aclk(aclk), .en(ce), .num(nty_c),
                       .den(tlqe_pkg::DIV_DEN_W'(wh_nz)), .quo(qty));

    logic [tlqe_pkg::DIV_QUO_W-1:0] dv_valid_reg;
    dv_side_t                       dv_side_reg [tlqe_pkg::DIV_QUO_W];
    dv_side_t                       dv_tail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg <= '0;
        end else if (ce) begin
            dv_valid_reg <= {dv_valid_reg[tlqe_pkg::DIV_QUO_W-2:0],
                             sq_valid_reg[tlqe_pkg::SQRT_STEPS-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv_side_reg[0] <= '{geom: sq_tail.geom, negx: sq_tail.negx, posy: sq_tail.posy};
            for (int i = 1; i < tlqe_pkg::DIV_QUO_W; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    assign dv_tail = dv_side_reg[tlqe_pkg::DIV_QUO_W-1];

    // Stage F: partial products of the offset
    logic        f_valid_reg;
    dv_side_t    f_side_reg;
    logic [34:0] f_ppx_hi_reg;
    logic [34:0] f_ppx_lo_reg;
    logic [34:0] f_ppy_hi_reg;
    logic [34:0] f_ppy_lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= dv_valid_reg[tlqe_pkg::DIV_QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_side_reg   <= dv_tail;
            f_ppx_hi_reg <= 35'(qux[16:0]) * 35'(qtx[35:18]);
            f_ppx_lo_reg <= 35'(qux[16:0]) * 35'(qtx[17:0]);
            f_ppy_hi_reg <= 35'(quy[16:0]) * 35'(qty[35:18]);
            f_ppy_lo_reg <= 35'(quy[16:0]) * 35'(qty[17:0]);
        end
    end

    // Stage G: rounded and limited offset
    localparam logic [30:0] OFS_LIMIT = 31'd33554432;
    localparam logic [53:0] OFS_HALF  = 54'd4194304;

    logic               g_valid_reg;
    geom_t              g_geom_reg;
    logic signed [26:0] g_ox_reg;
    logic signed [26:0] g_oy_reg;
    logic [53:0]        sumx_c;
    logic [53:0]        sumy_c;
    logic [30:0]        magx_c;
    logic [30:0]        magy_c;
    logic [25:0]        clx_c;
    logic [25:0]        cly_c;

    assign sumx_c = {1'b0, f_ppx_hi_reg, 18'd0} + 54'(f_ppx_lo_reg) + OFS_HALF;
    assign sumy_c = {1'b0, f_ppy_hi_reg, 18'd0} + 54'(f_ppy_lo_reg) + OFS_HALF;
    assign magx_c = sumx_c[53:23];
    assign magy_c = sumy_c[53:23];
    assign clx_c  = (magx_c > OFS_LIMIT) ? OFS_LIMIT[25:0] : magx_c[25:0];
    assign cly_c  = (magy_c > OFS_LIMIT) ? OFS_LIMIT[25:0] : magy_c[25:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= 1'b0;
        end else if (ce) begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            g_geom_reg <= f_side_reg.geom;
            g_ox_reg   <= f_side_reg.posy ? -$signed({1'b0, clx_c}) : $signed({1'b0, clx_c});
            g_oy_reg   <= f_side_reg.negx ? -$signed({1'b0, cly_c}) : $signed({1'b0, cly_c});
        end
    end

    // Stage H: corners, x in entries 0..3 and y in entries 4..7
    logic               h_valid_reg;
    color_t             h_color_reg;
    logic signed [27:0] h_c_reg [NCOORD];
    logic signed [27:0] sx_e;
    logic signed [27:0] sy_e;
    logic signed [27:0] ex_e;
    logic signed [27:0] ey_e;
    logic signed [27:0] ox_e;
    logic signed [27:0] oy_e;

    assign sx_e = {{4{g_geom_reg.sx[23]}}, g_geom_reg.sx};
    assign sy_e = {{4{g_geom_reg.sy[23]}}, g_geom_reg.sy};
    assign ex_e = {{4{g_geom_reg.ex[23]}}, g_geom_reg.ex};
    assign ey_e = {{4{g_geom_reg.ey[23]}}, g_geom_reg.ey};
    assign ox_e = {g_ox_reg[26], g_ox_reg};
    assign oy_e = {g_oy_reg[26], g_oy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (ce) begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_color_reg <= g_geom_reg.color;
            h_c_reg[0]  <= sx_e + ox_e;
            h_c_reg[1]  <= ex_e + ox_e;
            h_c_reg[2]  <= ex_e - ox_e;
            h_c_reg[3]  <= sx_e - ox_e;
            h_c_reg[4]  <= sy_e + oy_e;
            h_c_reg[5]  <= ey_e + oy_e;
            h_c_reg[6]  <= ey_e - oy_e;
            h_c_reg[7]  <= sy_e - oy_e;
        end
    end

    // Device coordinate dividers
    localparam logic [27:0] COORD_LIMIT = 28'd16777216;

    logic [tlqe_pkg::DIV_NUM_W-1:0] nd_num_c [NCOORD];
    logic [tlqe_pkg::DIV_DEN_W-1:0] nd_den_c [NCOORD];
    logic [tlqe_pkg::DIV_QUO_W-1:0] nd_quo   [NCOORD];
    logic [NCOORD-1:0]              nd_neg_c;

    always_comb begin
        logic [27:0] mag;
        logic [24:0] lim;
        for (int i = 0; i < NCOORD; i++) begin
            nd_neg_c[i] = h_c_reg[i][27];
            mag         = h_c_reg[i][27] ? 28'(-h_c_reg[i]) : 28'(h_c_reg[i]);
            lim         = (mag > COORD_LIMIT) ? COORD_LIMIT[24:0] : mag[24:0];
            if (i < NCOORD / 2) begin
                nd_den_c[i] = tlqe_pkg::DIV_DEN_W'(sw_nz);
                nd_num_c[i] = tlqe_pkg::DIV_NUM_W'({lim, 5'd0})
                            + tlqe_pkg::DIV_NUM_W'(sw_nz >> 1);
            end else begin
                nd_den_c[i] = tlqe_pkg::DIV_DEN_W'(sh_nz);
                nd_num_c[i] = tlqe_pkg::DIV_NUM_W'({lim, 5'd0})
                            + tlqe_pkg::DIV_NUM_W'(sh_nz >> 1);
            end
        end
    end

    for (genvar g = 0; g < NCOORD; g++) begin : g_ndc_div
        tlqe_div u_div_ndc (
            .aclk (aclk),
            .en   (ce),
            .num  (nd_num_c[g]),
            .den  (nd_den_c[g]),
            .quo  (nd_quo[g])
        );
    end

    logic [tlqe_pkg::DIV_QUO_W-1:0] nd_valid_reg;
    nd_side_t                       nd_side_reg [tlqe_pkg::DIV_QUO_W];
    nd_side_t                       nd_tail;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nd_valid_reg <= '0;
        end else if (ce) begin
            nd_valid_reg <= {nd_valid_reg[tlqe_pkg::DIV_QUO_W-2:0], h_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            nd_side_reg[0] <= '{color: h_color_reg, neg: nd_neg_c};
            for (int i = 1; i < tlqe_pkg::DIV_QUO_W; i++) begin
                nd_side_reg[i] <= nd_side_reg[i-1];
            end
        end
    end

    assign nd_tail = nd_side_reg[tlqe_pkg::DIV_QUO_W-1];

    // Stage K: bias and saturation
    function automatic logic signed [15:0] ndc_sat(input logic [tlqe_pkg::DIV_QUO_W-1:0] q,
                                                   input logic neg);
        logic signed [37:0] v;
        v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        v = v - 38'sd4096;
        if (v > 38'sd32767) begin
            return 16'sh7fff;
        end else if (v < -38'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    color_t             k_color_reg;
    logic signed [15:0] k_ndc_reg [NCOORD];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_valid_reg <= 1'b0;
        end else if (ce) begin
            k_valid_reg <= nd_valid_reg[tlqe_pkg::DIV_QUO_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k_color_reg <= nd_tail.color;
            for (int i = 0; i < NCOORD; i++) begin
                k_ndc_reg[i] <= ndc_sat(nd_quo[i], nd_tail.neg[i]);
            end
        end
    end

    // Vertex output register
    function automatic logic [1:0] corner_of(input logic [2:0] slot);
        case (slot)
            3'd1:    return 2'd1;
            3'd2:    return 2'd2;
            3'd3:    return 2'd2;
            3'd4:    return 2'd3;
            default: return 2'd0;
        endcase
    endfunction

    color_t             buf_color_reg;
    logic signed [15:0] buf_ndc_reg [NCOORD];
    logic [1:0]         corner_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            buf_slot_reg  <= '0;
        end else if (buf_free) begin
            buf_valid_reg <= k_valid_reg;
            buf_slot_reg  <= '0;
        end else if (m_ready) begin
            buf_slot_reg <= buf_slot_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_free) begin
            buf_color_reg <= k_color_reg;
            for (int i = 0; i < NCOORD; i++) begin
                buf_ndc_reg[i] <= k_ndc_reg[i];
            end
        end
    end

    assign corner_c = corner_of(buf_slot_reg);

    assign m_valid            = buf_valid_reg;
    assign m_data.ndc_x       = buf_ndc_reg[{1'b0, corner_c}];
    assign m_data.ndc_y       = buf_ndc_reg[{1'b1, corner_c}];
    assign m_data.out_red     = buf_color_reg.red;
    assign m_data.out_green   = buf_color_reg.green;
    assign m_data.out_blue    = buf_color_reg.blue;
    assign m_data.vertex_slot = buf_slot_reg;
    assign m_data.last_vertex = buf_slot_reg == tlqe_pkg::SLOT_LAST;

endmodule

// ===== src/tlqe_checker.sv =====
// ----------------------------------------------------------------------------
// Thick line quad expander checker
// Port-level properties of the vertex output channel.
// ----------------------------------------------------------------------------
module tlqe_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input tlqe_pkg::out_item_t m_data
);

    // A stalled transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled vertex changed");

    // Vertices of one quad follow each other without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_vertex |=>
            m_valid && m_data.vertex_slot == $past(m_data.vertex_slot) + 3'd1)
        else $error("vertex sequence broken");

    // The last flag marks the sixth vertex only.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.last_vertex == (m_data.vertex_slot == tlqe_pkg::SLOT_LAST))
        else $error("last flag does not match slot");

    // The color is constant across the vertices of one quad.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_vertex |=>
            m_data.out_red == $past(m_data.out_red)
            && m_data.out_green == $past(m_data.out_green)
            && m_data.out_blue == $past(m_data.out_blue))
        else $error("color changed within a quad");

endmodule

bind thick_line_quad_expander tlqe_checker u_tlqe_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Thick line quad expander testbench
// Drives segment transactions with random idling and long output hold-offs,
// predicts the six vertices of each nonzero-length segment in fixed point and
// compares whole vertex transactions. Registers are rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import tlqe_pkg::*;

    localparam int LATENCY     = 111;
    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    thick_line_quad_expander uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    logic [12:0] sim_w, sim_h;
    logic [13:0] win_w, win_h;

    in_item_t  segment_queue[$];
    out_item_t vertex_queue[$];
    int        errors;
    int        cycles;
    int        accepted;
    bit        calm;
    bit        hold_request;
    int        tx_gap;
    int        rx_gap;
    int        hold_count;

    function automatic longint rnd_div(longint num, longint den);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            rnd_div = (num < 0) ? -q : q;
        end
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            root_floor = r;
        end
    endfunction

    function automatic logic [15:0] ndc_of(longint c, longint span);
        longint n;
        begin
            n = rnd_div(c * 32, (span == 0) ? 1 : span) - 4096;
            if (n > 32767) n = 32767;
            if (n < -32768) n = -32768;
            ndc_of = n[15:0];
        end
    endfunction

    task automatic predict_vertices(input in_item_t seg);
        longint sx, sy, ex, ey, dx, dy, len, ux, uy, tx, ty, ox, oy;
        longint sw, sh, ww, wh;
        longint vx[4];
        longint vy[4];
        int corner[6];
        out_item_t v;
        begin
            corner = '{0, 1, 2, 2, 3, 0};
            sx = seg.start_x; sy = seg.start_y;
            ex = seg.end_x;   ey = seg.end_y;
            dx = ex - sx;
            dy = ey - sy;
            if (dx != 0 || dy != 0) begin
                len = root_floor(longint'(dx * dx + dy * dy) << 14);
                ux = rnd_div(-dy * (64'sd1 <<< 22), len);
                uy = rnd_div(dx * (64'sd1 <<< 22), len);
                sw = (sim_w == 0) ? 1 : sim_w;
                sh = (sim_h == 0) ? 1 : sim_h;
                ww = (win_w == 0) ? 1 : win_w;
                wh = (win_h == 0) ? 1 : win_h;
                tx = rnd_div(longint'(seg.thickness) * sw * 128, ww);
                ty = rnd_div(longint'(seg.thickness) * sh * 128, wh);
                ox = rnd_div(ux * tx, 64'sd1 <<< 23);
                oy = rnd_div(uy * ty, 64'sd1 <<< 23);
                vx[0] = sx + ox; vy[0] = sy + oy;
                vx[1] = ex + ox; vy[1] = ey + oy;
                vx[2] = ex - ox; vy[2] = ey - oy;
                vx[3] = sx - ox; vy[3] = sy - oy;
                for (int k = 0; k < 6; k++) begin
                    v.ndc_x       = ndc_of(vx[corner[k]], sim_w);
                    v.ndc_y       = ndc_of(vy[corner[k]], sim_h);
                    v.out_red     = seg.color_red;
                    v.out_green   = seg.color_green;
                    v.out_blue    = seg.color_blue;
                    v.vertex_slot = k[2:0];
                    v.last_vertex = (k == 5);
                    vertex_queue.push_back(v);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_vertices(s_data);
                accepted <= accepted + 1;
            end
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap  <= tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap  <= $urandom_range(1, 13);
                    s_valid <= 1'b0;
                end else if (segment_queue.size() > 0) begin
                    s_data  <= segment_queue.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            rx_gap     <= 0;
            hold_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (vertex_queue.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("Unexpected vertex transaction: %h", m_data);
                end else if (m_data !== vertex_queue[0]) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("Mismatch: expected %h actual %h",
                                 vertex_queue[0], m_data);
                    void'(vertex_queue.pop_front());
                end else begin
                    void'(vertex_queue.pop_front());
                end
            end
            if (hold_request && hold_count == 0) begin
                hold_count <= 400;
                m_ready    <= 1'b0;
            end else if (hold_count > 1) begin
                hold_count <= hold_count - 1;
                m_ready    <= 1'b0;
            end else if (rx_gap > 0) begin
                hold_count <= 0;
                rx_gap     <= rx_gap - 1;
                m_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold_count <= 0;
                rx_gap     <= $urandom_range(1, 13);
                m_ready    <= 1'b0;
            end else begin
                hold_count <= 0;
                m_ready    <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic in_item_t rand_segment();
        in_item_t seg;
        int span;
        begin
            seg.start_x = $urandom;
            seg.start_y = $urandom;
            case ($urandom_range(0, 3))
                0: begin
                    seg.end_x = $urandom;
                    seg.end_y = $urandom;
                end
                1: begin
                    span = $urandom_range(1, 1 << 20);
                    seg.end_x = seg.start_x + $signed($urandom_range(0, 2 * span) - span);
                    seg.end_y = seg.start_y + $signed($urandom_range(0, 2 * span) - span);
                end
                2: begin
                    seg.start_x = $signed($urandom_range(0, 262143));
                    seg.start_y = $signed($urandom_range(0, 262143));
                    seg.end_x   = $signed($urandom_range(0, 262143));
                    seg.end_y   = $signed($urandom_range(0, 262143));
                end
                default: begin
                    seg.end_x = seg.start_x + $signed($urandom_range(0, 8) - 4);
                    seg.end_y = seg.start_y + $signed($urandom_range(0, 8) - 4);
                end
            endcase
            seg.thickness   = ($urandom_range(0, 5) == 0) ? 16'(0) : 16'($urandom);
            seg.color_red   = $urandom;
            seg.color_green = $urandom;
            seg.color_blue  = $urandom;
            rand_segment = seg;
        end
    endfunction

    function automatic in_item_t make_segment(int sx, int sy, int ex, int ey, int th);
        in_item_t seg;
        begin
            seg.start_x     = sx;
            seg.start_y     = sy;
            seg.end_x       = ex;
            seg.end_y       = ey;
            seg.thickness   = th;
            seg.color_red   = $urandom;
            seg.color_green = $urandom;
            seg.color_blue  = $urandom;
            make_segment = seg;
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value[CFG_DATA_W-1:0];
            if (idx == CFG_SIM_WIDTH) sim_w = value[12:0];
            if (idx == CFG_SIM_HEIGHT) sim_h = value[12:0];
            if (idx == CFG_WINDOW_WIDTH) win_w = value[13:0];
            if (idx == CFG_WINDOW_HEIGHT) win_h = value[13:0];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
        end
    endtask

    task automatic write_setting(input int sw, input int sh, input int ww, input int wh);
        begin
            write_reg(CFG_SIM_WIDTH, sw);
            write_reg(CFG_SIM_HEIGHT, sh);
            write_reg(CFG_WINDOW_WIDTH, ww);
            write_reg(CFG_WINDOW_HEIGHT, wh);
        end
    endtask

    task automatic drain();
        begin
            while (segment_queue.size() > 0 || s_valid || vertex_queue.size() > 0)
                @(posedge aclk);
            repeat (LATENCY + 20) @(posedge aclk);
        end
    endtask

    initial begin
        errors       = 0;
        cycles       = 0;
        accepted     = 0;
        calm         = 1'b0;
        hold_request = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        sim_w = 1024; sim_h = 1024; win_w = 1024; win_h = 1024;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        segment_queue.push_back(make_segment(0, 0, 256, 0, 256));
        segment_queue.push_back(make_segment(0, 0, 0, 256, 512));
        segment_queue.push_back(make_segment(100, 200, 100, 200, 1000));
        segment_queue.push_back(make_segment(-8388608, -8388608, 8388607, 8388607, 65535));
        segment_queue.push_back(make_segment(8388607, -8388608, -8388608, 8388607, 0));
        segment_queue.push_back(make_segment(0, 0, 1, 0, 65535));
        segment_queue.push_back(make_segment(0, 0, 0, -1, 65535));
        segment_queue.push_back(make_segment(8388607, 8388607, 8388606, 8388607, 65535));
        segment_queue.push_back(make_segment(131072, 131072, 262144, 131072, 0));
        segment_queue.push_back(make_segment(-5000, 3000, 7000, -9000, 12345));
        segment_queue.push_back(make_segment(-8388608, 0, -8388608, 0, 65535));
        for (int i = 0; i < 6; i++)
            segment_queue.push_back(rand_segment());
        drain();

        write_setting(4096, 4096, 1, 1);
        segment_queue.push_back(make_segment(0, 0, 256, 256, 65535));
        segment_queue.push_back(make_segment(-8388608, 8388607, 0, 0, 65535));
        hold_request = 1'b1;
        for (int i = 0; i < 120; i++)
            segment_queue.push_back(rand_segment());
        @(posedge aclk);
        hold_request = 1'b0;
        drain();

        write_setting(1, 1, 8192, 8192);
        for (int i = 0; i < 80; i++)
            segment_queue.push_back(rand_segment());
        drain();

        write_setting(0, 0, 0, 0);
        for (int i = 0; i < 40; i++)
            segment_queue.push_back(rand_segment());
        drain();

        write_setting(8191, 8191, 16383, 16383);
        for (int i = 0; i < 40; i++)
            segment_queue.push_back(rand_segment());
        drain();

        write_setting($urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(1, 8192), $urandom_range(1, 8192));
        for (int i = 0; i < 110; i++)
            segment_queue.push_back(rand_segment());
        drain();

        write_reg(3'd6, $urandom);
        calm = 1'b1;
        for (int i = 0; i < 60; i++)
            segment_queue.push_back(rand_segment());
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
src/tlqe_pkg.sv
src/tlqe_sqrt.sv
src/tlqe_div.sv
src/thick_line_quad_expander.sv
src/tlqe_checker.sv
dv/testbench.sv
